// ===== src/tbe_pkg.sv =====
// shared types, codes and helper functions of the two-body euler step block
`timescale 1ns / 1ps
package tbe_pkg;

  typedef enum logic {
    DS_DIV  = 1'b0,
    DS_SQRT = 1'b1
  } ds_op_e;

  localparam logic CFG_GRAV = 1'b0;
  localparam logic CFG_DT   = 1'b1;

  localparam int unsigned DT_FRAC = 16;

  localparam logic [31:0] GRAV_RESET = 32'd398600;
  localparam logic [31:0] DT_RESET   = 32'd65536;

  typedef struct packed {
    logic        ovf;
    logic [63:0] val;
  } sum_t;

  // scale a 128-bit product by 2^-16, saturating to 64 bits
  function automatic logic [63:0] scale_dt(input logic [127:0] p);
    logic [63:0] r;
    if (p[127:64+DT_FRAC] != '0) begin
      r = '1;
    end else begin
      r = p[64+DT_FRAC-1:DT_FRAC];
    end
    return r;
  endfunction

  // old plus or minus a magnitude, in offset-binary to catch range overflow
  function automatic sum_t add_signed(input logic [63:0] old, input logic neg,
                                      input logic [63:0] m);
    logic [63:0] b;
    logic [64:0] s;
    sum_t        r;
    b = old ^ {1'b1, 63'b0};
    r.ovf = 1'b0;
    r.val = old;
    if (neg) begin
      s = {1'b0, b} - {1'b0, m};
    end else begin
      s = {1'b0, b} + {1'b0, m};
    end
    if (s[64]) begin
      r.ovf = 1'b1;
    end else begin
      r.val = s[63:0] ^ {1'b1, 63'b0};
    end
    return r;
  endfunction

endpackage

// ===== src/tbe_mul.sv =====
// iterative 64x64 unsigned multiplier built on one 32x32 partial product unit
`timescale 1ns / 1ps
module tbe_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] p_o
);

  logic         busy_q;
  logic [2:0]   step_q;
  logic [63:0]  a_q, b_q;
  logic [63:0]  prod_q;
  logic [1:0]   sh_q;
  logic [127:0] acc_q;
  logic         done_q;
  logic [31:0]  ah, bh;
  logic [127:0] part;

  assign ah = step_q[0] ? a_q[63:32] : a_q[31:0];
  assign bh = step_q[1] ? b_q[63:32] : b_q[31:0];

  always_comb begin
    case (sh_q)
      2'd0:    part = {64'b0, prod_q};
      2'd1:    part = {32'b0, prod_q, 32'b0};
      2'd2:    part = {prod_q, 64'b0};
      default: part = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q != 3'd4) begin
        prod_q <= {32'b0, ah} * {32'b0, bh};
        sh_q   <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
      end
      if (step_q != 3'd0) begin
        acc_q <= acc_q + part;
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ===== src/tbe_divsqrt.sv =====
// shared bit-serial unit: 128/64 saturating divide or 128-bit integer square root
`timescale 1ns / 1ps
module tbe_divsqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  tbe_pkg::ds_op_e op_i,
  input  logic [127:0]    num_i,
  input  logic [63:0]     den_i,
  output logic            done_o,
  output logic [63:0]     res_o
);

  logic            busy_q;
  logic            done_q;
  logic [5:0]      cnt_q;
  tbe_pkg::ds_op_e op_q;
  logic [67:0]     rem_q;
  logic [127:0]    rad_q;
  logic [63:0]     den_q;
  logic [63:0]     root_q;
  logic [64:0]     dsh;
  logic [67:0]     ssh, trial;
  logic            dbit, sbit;

  assign dsh   = {rem_q[63:0], rad_q[127]};
  assign dbit  = (dsh >= {1'b0, den_q});
  assign ssh   = {rem_q[65:0], rad_q[127:126]};
  assign trial = {2'b0, root_q, 2'b01};
  assign sbit  = (ssh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= 6'd63;
        if (op_i == tbe_pkg::DS_DIV && (den_i == '0 || num_i[127:64] >= den_i)) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q  <= op_i;
      den_q <= den_i;
      if (op_i == tbe_pkg::DS_DIV) begin
        rem_q  <= {4'b0, num_i[127:64]};
        rad_q  <= {num_i[63:0], 64'b0};
        root_q <= (den_i == '0 || num_i[127:64] >= den_i) ? '1 : '0;
      end else begin
        rem_q  <= '0;
        rad_q  <= num_i;
        root_q <= '0;
      end
    end else if (busy_q) begin
      if (op_q == tbe_pkg::DS_DIV) begin
        rad_q  <= {rad_q[126:0], 1'b0};
        root_q <= {root_q[62:0], dbit};
        rem_q  <= dbit ? {4'b0, 64'(dsh - {1'b0, den_q})} : {4'b0, dsh[63:0]};
      end else begin
        rad_q  <= {rad_q[125:0], 2'b0};
        root_q <= {root_q[62:0], sbit};
        rem_q  <= sbit ? (ssh - trial) : ssh;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = root_q;

endmodule

// ===== src/two_body_euler_step.sv =====
// top level: two-body orbit state, explicit euler step sequencer over shared units
//
// input channel (in_valid_i / in_ready_o) carries one transaction: mode_i and
// the six state fields. mode 0 loads the state, mode 1 advances one step.
// output channel (out_valid_o / out_ready_i) returns the state after each
// transaction plus fault_o. config writes go through cfg_we_i / cfg_idx_i /
// cfg_data_i (index 0 grav_param, index 1 time_step); the user must make
// them only while the block is idle, the block itself does not enforce it.
// a load goes from accept straight to the result stage. a step runs three
// multiplies for r^2, a square root, two divides for mu/r^2, then per axis
// a multiply, a divide and two multiplies, then commits and issues the
// result; a saturating divide ends without iterating and a zero radius
// stops after the square root.
// one transaction is in work at a time; in_ready_o is high only when idle.
// a finished result waits in the output register while the receiver stalls,
// and the next transaction may be accepted meanwhile.
// zero radius or range overflow keeps the state and raises fault_o.
// reset clears the state to zero and loads the default config values.
`timescale 1ns / 1ps
module two_body_euler_step #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic signed [63:0] pos_x_i,
  input  logic signed [63:0] pos_y_i,
  input  logic signed [63:0] pos_z_i,
  input  logic signed [63:0] vel_x_i,
  input  logic signed [63:0] vel_y_i,
  input  logic signed [63:0] vel_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] new_pos_x_o,
  output logic signed [63:0] new_pos_y_o,
  output logic signed [63:0] new_pos_z_o,
  output logic signed [63:0] new_vel_x_o,
  output logic signed [63:0] new_vel_y_o,
  output logic signed [63:0] new_vel_z_o,
  output logic               fault_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ   = 4'd1;
  localparam logic [3:0] ST_SQRT = 4'd2;
  localparam logic [3:0] ST_DIV1 = 4'd3;
  localparam logic [3:0] ST_DIV2 = 4'd4;
  localparam logic [3:0] ST_MG   = 4'd5;
  localparam logic [3:0] ST_DA   = 4'd6;
  localparam logic [3:0] ST_MV   = 4'd7;
  localparam logic [3:0] ST_MP   = 4'd8;
  localparam logic [3:0] ST_CMT  = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;

  localparam int unsigned GSHIFT = 2 * FRAC_BITS;

  logic [3:0]   st_q;
  logic [1:0]   ax_q;
  logic         launch_q;
  logic [31:0]  gp_q, ts_q;
  logic [63:0]  pos_q [3];
  logic [63:0]  vel_q [3];
  logic [63:0]  pm_q  [3];
  logic [63:0]  vm_q  [3];
  logic [63:0]  np_q  [3];
  logic [63:0]  nv_q  [3];
  logic [127:0] r2_q;
  logic [63:0]  r_q, g_q, a_q, dv_q;
  logic         ovf_q, fault_q;
  logic         out_valid_q, out_fault_q;
  logic [63:0]  out_pos_q [3];
  logic [63:0]  out_vel_q [3];

  logic            mul_start, mul_done;
  logic [63:0]     mul_a, mul_b;
  logic [127:0]    mul_p;
  logic            ds_start, ds_done;
  tbe_pkg::ds_op_e ds_op;
  logic [127:0]    ds_num;
  logic [63:0]     ds_res;
  logic            accept;
  logic [63:0]     in_pos [3];
  logic [63:0]     in_vel [3];
  tbe_pkg::sum_t   psum, vsum;

  assign in_pos[0] = pos_x_i;
  assign in_pos[1] = pos_y_i;
  assign in_pos[2] = pos_z_i;
  assign in_vel[0] = vel_x_i;
  assign in_vel[1] = vel_y_i;
  assign in_vel[2] = vel_z_i;

  assign in_ready_o = (st_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    mul_start = 1'b0;
    mul_a     = pm_q[ax_q];
    mul_b     = pm_q[ax_q];
    ds_start  = 1'b0;
    ds_op     = tbe_pkg::DS_DIV;
    ds_num    = mul_p;
    case (st_q)
      ST_SQ: begin
        mul_start = launch_q;
      end
      ST_MG: begin
        mul_start = launch_q;
        mul_a     = g_q;
      end
      ST_MV: begin
        mul_start = launch_q;
        mul_a     = {32'b0, ts_q};
        mul_b     = a_q;
      end
      ST_MP: begin
        mul_start = launch_q;
        mul_a     = {32'b0, ts_q};
        mul_b     = vm_q[ax_q];
      end
      ST_SQRT: begin
        ds_start = launch_q;
        ds_op    = tbe_pkg::DS_SQRT;
        ds_num   = r2_q;
      end
      ST_DIV1: begin
        ds_start = launch_q;
        ds_num   = {96'b0, gp_q} << GSHIFT;
      end
      ST_DIV2: begin
        ds_start = launch_q;
        ds_num   = {64'b0, g_q} << FRAC_BITS;
      end
      ST_DA: begin
        ds_start = launch_q;
      end
      default: begin
      end
    endcase
  end

  assign psum = tbe_pkg::add_signed(pos_q[ax_q], vel_q[ax_q][63],
                                    tbe_pkg::scale_dt(mul_p));
  assign vsum = tbe_pkg::add_signed(vel_q[ax_q], !pos_q[ax_q][63], dv_q);

  tbe_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  tbe_divsqrt u_divsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ds_start),
    .op_i    (ds_op),
    .num_i   (ds_num),
    .den_i   (r_q),
    .done_o  (ds_done),
    .res_o   (ds_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q <= tbe_pkg::GRAV_RESET;
      ts_q <= tbe_pkg::DT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tbe_pkg::CFG_GRAV) begin
        gp_q <= cfg_data_i;
      end else begin
        ts_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ax_q        <= '0;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
      fault_q     <= 1'b0;
      ovf_q       <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else begin
      launch_q <= 1'b0;
      if (out_valid_q && out_ready_i && st_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (accept) begin
            if (!mode_i) begin
              for (int i = 0; i < 3; i++) begin
                pos_q[i] <= in_pos[i];
                vel_q[i] <= in_vel[i];
              end
              fault_q <= 1'b0;
              st_q    <= ST_FIN;
            end else begin
              ax_q     <= '0;
              launch_q <= 1'b1;
              st_q     <= ST_SQ;
            end
          end
        end
        ST_SQ: begin
          if (mul_done) begin
            launch_q <= 1'b1;
            if (ax_q == 2'd2) begin
              st_q <= ST_SQRT;
            end else begin
              ax_q <= ax_q + 2'd1;
            end
          end
        end
        ST_SQRT: begin
          if (ds_done) begin
            if (ds_res == '0) begin
              fault_q <= 1'b1;
              st_q    <= ST_FIN;
            end else begin
              launch_q <= 1'b1;
              st_q     <= ST_DIV1;
            end
          end
        end
        ST_DIV1: begin
          if (ds_done) begin
            launch_q <= 1'b1;
            st_q     <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (ds_done) begin
            ax_q     <= '0;
            ovf_q    <= 1'b0;
            launch_q <= 1'b1;
            st_q     <= ST_MG;
          end
        end
        ST_MG: begin
          if (mul_done) begin
            launch_q <= 1'b1;
            st_q     <= ST_DA;
          end
        end
        ST_DA: begin
          if (ds_done) begin
            launch_q <= 1'b1;
            st_q     <= ST_MV;
          end
        end
        ST_MV: begin
          if (mul_done) begin
            launch_q <= 1'b1;
            st_q     <= ST_MP;
          end
        end
        ST_MP: begin
          if (mul_done) begin
            ovf_q <= ovf_q | psum.ovf | vsum.ovf;
            if (ax_q == 2'd2) begin
              st_q <= ST_CMT;
            end else begin
              ax_q     <= ax_q + 2'd1;
              launch_q <= 1'b1;
              st_q     <= ST_MG;
            end
          end
        end
        ST_CMT: begin
          fault_q <= ovf_q;
          if (!ovf_q) begin
            for (int i = 0; i < 3; i++) begin
              pos_q[i] <= np_q[i];
              vel_q[i] <= nv_q[i];
            end
          end
          st_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            st_q        <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && mode_i) begin
      r2_q <= '0;
      for (int i = 0; i < 3; i++) begin
        pm_q[i] <= pos_q[i][63] ? (64'd0 - pos_q[i]) : pos_q[i];
        vm_q[i] <= vel_q[i][63] ? (64'd0 - vel_q[i]) : vel_q[i];
      end
    end
    if (st_q == ST_SQ && mul_done) begin
      r2_q <= r2_q + mul_p;
    end
    if (st_q == ST_SQRT && ds_done) begin
      r_q <= ds_res;
    end
    if ((st_q == ST_DIV1 || st_q == ST_DIV2) && ds_done) begin
      g_q <= ds_res;
    end
    if (st_q == ST_DA && ds_done) begin
      a_q <= ds_res;
    end
    if (st_q == ST_MV && mul_done) begin
      dv_q <= tbe_pkg::scale_dt(mul_p);
    end
    if (st_q == ST_MP && mul_done) begin
      np_q[ax_q] <= psum.val;
      nv_q[ax_q] <= vsum.val;
    end
    if (st_q == ST_FIN && (!out_valid_q || out_ready_i)) begin
      out_fault_q <= fault_q;
      for (int i = 0; i < 3; i++) begin
        out_pos_q[i] <= pos_q[i];
        out_vel_q[i] <= vel_q[i];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign fault_o     = out_fault_q;
  assign new_pos_x_o = out_pos_q[0];
  assign new_pos_y_o = out_pos_q[1];
  assign new_pos_z_o = out_pos_q[2];
  assign new_vel_x_o = out_vel_q[0];
  assign new_vel_y_o = out_vel_q[1];
  assign new_vel_z_o = out_vel_q[2];

endmodule

// ===== src/tbe_checker.sv =====
// port-level checks of the two-body euler step block, bound to the top level
`timescale 1ns / 1ps
module tbe_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        mode_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] new_pos_x_o,
  input logic        fault_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_pos_x_o) && $stable(fault_o))
    else $error("stalled result changed");

  // one transaction in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted while busy");

  // a load with a free output port returns through the finish state and the output register without fault
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !mode_i && !out_valid_o |-> ##2 out_valid_o && !fault_o)
    else $error("load result missing");

endmodule

bind two_body_euler_step tbe_port_checks u_tbe_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .mode_i      (mode_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .new_pos_x_o (new_pos_x_o),
  .fault_o     (fault_o)
);

// ===== verif/tbe_checker.sv =====
// checker: predicts the orbit state after each transaction and compares results
`timescale 1ns / 1ps
module tbe_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        mode_i,
  input  logic [63:0] pos_x_i,
  input  logic [63:0] pos_y_i,
  input  logic [63:0] pos_z_i,
  input  logic [63:0] vel_x_i,
  input  logic [63:0] vel_y_i,
  input  logic [63:0] vel_z_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] new_pos_x_i,
  input  logic [63:0] new_pos_y_i,
  input  logic [63:0] new_pos_z_i,
  input  logic [63:0] new_vel_x_i,
  input  logic [63:0] new_vel_y_i,
  input  logic [63:0] new_vel_z_i,
  input  logic        fault_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          fault_count_o
);

  localparam logic [63:0] SIGN = {1'b1, 63'b0};

  typedef struct {
    logic [2:0][63:0] pos;
    logic [2:0][63:0] vel;
    logic             fault;
  } orbit_t;

  logic [31:0]      mu;
  logic [31:0]      dt;
  logic [2:0][63:0] pos_st;
  logic [2:0][63:0] vel_st;
  orbit_t           state_q[$];

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] isqrt(input logic [127:0] s);
    logic [63:0]  res;
    logic [63:0]  c;
    logic [127:0] sq;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = res | (64'd1 << b);
      sq = {64'b0, c} * {64'b0, c};
      if (sq <= s) res = c;
    end
    return res;
  endfunction

  function automatic logic [63:0] div_sat(input logic [127:0] n, input logic [63:0] d);
    logic [127:0] q;
    if (d == '0 || n[127:64] >= d) return '1;
    q = n / {64'b0, d};
    return q[63:0];
  endfunction

  function automatic logic [63:0] times_dt(input logic [63:0] m);
    logic [127:0] p;
    p = {96'b0, dt} * {64'b0, m};
    if (p[127:80] != '0) return '1;
    return p[79:16];
  endfunction

  // offset binary sum, flags range overflow
  function automatic logic [63:0] shift_by(input logic [63:0] old, input logic neg,
                                           input logic [63:0] m, inout logic ovf);
    logic [63:0] b;
    b = old ^ SIGN;
    if (neg) begin
      if (m > b) begin
        ovf = 1'b1;
        return old;
      end
      b = b - m;
    end else begin
      if (m > ~b) begin
        ovf = 1'b1;
        return old;
      end
      b = b + m;
    end
    return b ^ SIGN;
  endfunction

  function automatic orbit_t advance_state();
    orbit_t           o;
    logic [2:0][63:0] pm;
    logic [2:0][63:0] np;
    logic [2:0][63:0] nv;
    logic [127:0]     r2;
    logic [63:0]      r;
    logic [63:0]      q1;
    logic [63:0]      g;
    logic [63:0]      acc;
    logic             ovf;
    r2  = '0;
    ovf = 1'b0;
    o.fault = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pm[i] = mag(pos_st[i]);
      r2 = r2 + {64'b0, pm[i]} * {64'b0, pm[i]};
    end
    r = isqrt(r2);
    if (r == '0) begin
      o.fault = 1'b1;
    end else begin
      q1 = div_sat({32'b0, mu, 64'b0}, r);
      g  = div_sat({32'b0, q1, 32'b0}, r);
      for (int i = 0; i < 3; i++) begin
        acc   = div_sat({64'b0, g} * {64'b0, pm[i]}, r);
        np[i] = shift_by(pos_st[i], vel_st[i][63], times_dt(mag(vel_st[i])), ovf);
        nv[i] = shift_by(vel_st[i], !pos_st[i][63], times_dt(acc), ovf);
      end
      if (ovf) begin
        o.fault = 1'b1;
      end else begin
        pos_st = np;
        vel_st = nv;
      end
    end
    o.pos = pos_st;
    o.vel = vel_st;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      fail_count_o++;
      $display("%0t mismatch %s expected %h actual %h", $time, name, e, a);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    orbit_t o;
    if (!rst_ni) begin
      mu     <= tbe_pkg::GRAV_RESET;
      dt     <= tbe_pkg::DT_RESET;
      pos_st = '0;
      vel_st = '0;
      state_q.delete();
      pending_o     <= 0;
      fail_count_o  <= 0;
      fault_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (state_q.size() == 0) begin
          fail_count_o++;
          $display("%0t unexpected result transaction, none pending", $time);
        end else begin
          o = state_q.pop_front();
          check_field("new_pos_x", o.pos[0], new_pos_x_i);
          check_field("new_pos_y", o.pos[1], new_pos_y_i);
          check_field("new_pos_z", o.pos[2], new_pos_z_i);
          check_field("new_vel_x", o.vel[0], new_vel_x_i);
          check_field("new_vel_y", o.vel[1], new_vel_y_i);
          check_field("new_vel_z", o.vel[2], new_vel_z_i);
          check_field("fault", {63'b0, o.fault}, {63'b0, fault_i});
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (!mode_i) begin
          pos_st  = {pos_z_i, pos_y_i, pos_x_i};
          vel_st  = {vel_z_i, vel_y_i, vel_x_i};
          o.pos   = pos_st;
          o.vel   = vel_st;
          o.fault = 1'b0;
        end else begin
          o = advance_state();
        end
        if (o.fault) fault_count_o++;
        state_q.push_back(o);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == tbe_pkg::CFG_GRAV) mu <= cfg_data_i;
        else dt <= cfg_data_i;
      end
      pending_o <= state_q.size();
    end
  end
endmodule

// ===== verif/tb_two_body_euler_step.sv =====
// testbench top: stimulus, config phases, watchdog and verdict for the euler step block
`timescale 1ns / 1ps
module tb_two_body_euler_step;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int LONG_HOLD      = 3000;
  localparam int RANDOM_ITEMS   = 900;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        mode_i = 1'b0;
  logic [63:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [63:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] new_pos_x_o, new_pos_y_o, new_pos_z_o;
  logic [63:0] new_vel_x_o, new_vel_y_o, new_vel_z_o;
  logic        fault_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = tbe_pkg::CFG_GRAV;
  logic [31:0] cfg_data_i = '0;

  int fail_count, pending, fault_count;
  int n_load, n_step, n_cfg, idle_cnt;
  bit no_idle, hold_req;

  two_body_euler_step dut (.*);

  tbe_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .mode_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .vel_x_i, .vel_y_i, .vel_z_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .new_pos_x_i(new_pos_x_o), .new_pos_y_i(new_pos_y_o), .new_pos_z_i(new_pos_z_o),
    .new_vel_x_i(new_vel_x_o), .new_vel_y_i(new_vel_y_o), .new_vel_z_i(new_vel_z_o),
    .fault_i(fault_o), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .fault_count_o(fault_count)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("two_body_euler_step regression: fail");
        $finish;
      end
    end
  end

  // result side: random stall bursts plus one long hold
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send(input logic mode, input logic [5:0][63:0] f);
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    pos_x_i    <= f[0];
    pos_y_i    <= f[1];
    pos_z_i    <= f[2];
    vel_x_i    <= f[3];
    vel_y_i    <= f[4];
    vel_z_i    <= f[5];
    if (mode) n_step++;
    else n_load++;
    while (!in_ready_o) @(negedge clk_i);
    @(negedge clk_i);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
  endtask

  task automatic step_once();
    send(1'b1, {6{64'($urandom) << 32 | 64'($urandom)}});
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 || !in_ready_o) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [31:0] mu, input logic [31:0] dt);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= tbe_pkg::CFG_GRAV;
    cfg_data_i <= mu;
    @(negedge clk_i);
    cfg_idx_i  <= tbe_pkg::CFG_DT;
    cfg_data_i <= dt;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    n_cfg++;
  endtask

  function automatic logic [63:0] km(input int lim);
    int k;
    k = int'($urandom_range(0, 2 * lim)) - lim;
    return {32'(k), 32'($urandom)};
  endfunction

  function automatic logic [63:0] raw64();
    return {32'($urandom), 32'($urandom)};
  endfunction

  task automatic orbit_run(input int lim_p, input int lim_v, input int steps);
    send(1'b0, {km(lim_v), km(lim_v), km(lim_v), km(lim_p), km(lim_p), km(lim_p)});
    repeat (steps) step_once();
  endtask

  logic [63:0] maxp, minn, one_km;
  logic [31:0] mu_set[6];
  logic [31:0] dt_set[6];
  int per_phase;

  initial begin
    maxp   = {1'b0, {63{1'b1}}};
    minn   = {1'b1, 63'b0};
    one_km = 64'd1 << 32;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero radius straight after reset
    step_once();
    // low earth orbit, a few steps
    send(1'b0, {64'd0, 64'h7_AB85_1EB8, 64'd0, 64'd0, 64'd0, 64'd6778 << 32});
    repeat (3) step_once();
    // extremes: overflow on position and on velocity
    send(1'b0, {maxp, maxp, maxp, maxp, maxp, maxp});
    step_once();
    send(1'b0, {minn, minn, minn, minn, minn, minn});
    step_once();
    // tiny radius saturates the divides
    send(1'b0, {64'd0, 64'd0, 64'd0, 64'd1, 64'd0, 64'd0});
    step_once();
    send(1'b0, {64'd0, one_km, -one_km, -64'd1, 64'd0, 64'd1});
    step_once();
    // zero position with motion is still a zero radius
    send(1'b0, {one_km, one_km, one_km, 64'd0, 64'd0, 64'd0});
    step_once();
    send(1'b0, {64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0});
    step_once();

    // sender pauses until everything is back, then the long receiver hold
    drain();
    hold_req = 1'b1;
    orbit_run(42000, 10, 4);

    mu_set = '{32'd398600, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd4903, 32'd398600};
    dt_set = '{32'd60 << 16, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd10 << 16, 32'd65536};
    per_phase = RANDOM_ITEMS / 6;
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(mu_set[ph], dt_set[ph]);
      if (ph == 5) no_idle = 1'b1;
      for (int base = n_load + n_step; n_load + n_step < base + per_phase;) begin
        case ($urandom_range(0, 9))
          0: send(1'b0, {raw64(), raw64(), raw64(), raw64(), raw64(), raw64()});
          1: begin
            send(1'b0, {raw64(), raw64(), raw64(), raw64(), raw64(), raw64()});
            step_once();
          end
          2: step_once();
          3: orbit_run(2000000000, 2000000000, $urandom_range(1, 3));
          default: orbit_run(50000, 12, $urandom_range(1, 8));
        endcase
      end
    end

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("covered %0d loads and %0d steps over %0d register settings",
             n_load, n_step, n_cfg);
    $display("%0d results carried fault, %0d mismatches", fault_count, fail_count);
    if (fail_count == 0) begin
      $display("two_body_euler_step regression: pass");
    end else begin
      $display("two_body_euler_step regression: fail");
    end
    $finish;
  end
endmodule
